// ===== sv/msb_pkg.sv =====
// Shared constants, types and state encodings for the merge sort buffer.
package msb_pkg;

    localparam int DEPTH      = 32;
    localparam int DATA_WIDTH = 64;
    localparam int OUT_W      = 64;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int SUM_W      = CNT_W + 2;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SORT_GO,
        ST_SORT_WAIT,
        ST_EMIT_RD,
        ST_EMIT_CAP
    } t_top_state;

    typedef enum logic [2:0] {
        SS_IDLE,
        SS_PASS,
        SS_RUN,
        SS_LOAD_A,
        SS_LOAD_B,
        SS_MERGE,
        SS_FETCH_A,
        SS_FETCH_B
    } t_sort_state;

    typedef struct packed {
        logic                  we;
        logic                  src_scratch;
        logic [IDX_W-1:0]      waddr;
        logic [DATA_WIDTH-1:0] wdata;
        logic [IDX_W-1:0]      raddr;
    } t_ram_req;

    typedef struct packed {
        logic done;
        logic res_scratch;
    } t_sort_status;

endpackage

// ===== sv/msb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module msb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

// ===== sv/msb_sorter.sv =====
// Bottom-up merge engine: passes of run merges between the two buffers.
module msb_sorter
    import msb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [CNT_W-1:0]      i_count,
    input  logic [DATA_WIDTH-1:0] i_store_q,
    input  logic [DATA_WIDTH-1:0] i_scratch_q,
    output t_ram_req              o_req,
    output t_sort_status          o_status
);

    t_sort_state r_state, n_state;
    logic                  r_src;       // 1: source run data lives in scratch
    logic [CNT_W-1:0]      r_n;
    logic [SUM_W-1:0]      r_w;
    logic [SUM_W-1:0]      r_lo;
    logic [CNT_W-1:0]      r_a, r_b, r_k, r_mid, r_hi;
    logic [DATA_WIDTH-1:0] r_head_a, r_head_b;

    logic [DATA_WIDTH-1:0] rdata;
    logic [SUM_W-1:0]      n_ext, w2, mid_s, hi_s;
    logic [CNT_W-1:0]      mid_c, hi_c, a_inc, b_inc;
    logic                  pass_done, run_done, merge_done;
    logic                  a_left, b_left, take_left;

    assign rdata      = r_src ? i_scratch_q : i_store_q;
    assign n_ext      = SUM_W'(r_n);
    assign w2         = r_w << 1;
    assign mid_s      = r_lo + r_w;
    assign hi_s       = r_lo + w2;
    assign mid_c      = (mid_s > n_ext) ? r_n : mid_s[CNT_W-1:0];
    assign hi_c       = (hi_s > n_ext) ? r_n : hi_s[CNT_W-1:0];
    assign pass_done  = (r_w >= n_ext);
    assign run_done   = (r_lo >= n_ext);
    assign merge_done = (r_k >= r_hi);
    assign a_inc      = r_a + CNT_W'(1);
    assign b_inc      = r_b + CNT_W'(1);
    assign a_left     = (r_a < r_mid);
    assign b_left     = (r_b < r_hi);
    // stable: equal keys take the left run
    assign take_left  = a_left && (!b_left || ($signed(r_head_a) <= $signed(r_head_b)));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            SS_IDLE:    if (i_start) n_state = SS_PASS;
            SS_PASS:    n_state = pass_done ? SS_IDLE : SS_RUN;
            SS_RUN:     n_state = run_done ? SS_PASS : SS_LOAD_A;
            SS_LOAD_A:  n_state = SS_LOAD_B;
            SS_LOAD_B:  n_state = SS_MERGE;
            SS_MERGE: begin
                priority if (merge_done) begin
                    n_state = SS_RUN;
                end else if (take_left) begin
                    n_state = (a_inc < r_mid) ? SS_FETCH_A : SS_MERGE;
                end else begin
                    n_state = (b_inc < r_hi) ? SS_FETCH_B : SS_MERGE;
                end
            end
            SS_FETCH_A: n_state = SS_MERGE;
            SS_FETCH_B: n_state = SS_MERGE;
            default:    n_state = SS_IDLE;
        endcase
    end

    // memory requests and status
    always_comb begin
        o_req.we          = 1'b0;
        o_req.src_scratch = r_src;
        o_req.waddr       = r_k[IDX_W-1:0];
        o_req.wdata       = take_left ? r_head_a : r_head_b;
        o_req.raddr       = r_lo[IDX_W-1:0];
        o_status.done        = 1'b0;
        o_status.res_scratch = r_src;
        unique case (r_state)
            SS_PASS:   o_status.done = pass_done;
            SS_LOAD_A: o_req.raddr = r_b[IDX_W-1:0];
            SS_MERGE: begin
                o_req.we    = !merge_done;
                o_req.raddr = take_left ? a_inc[IDX_W-1:0] : b_inc[IDX_W-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SS_IDLE;
            r_src   <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                SS_IDLE: begin
                    if (i_start) begin
                        r_n   <= i_count;
                        r_w   <= SUM_W'(1);
                        r_src <= 1'b0;
                    end
                end
                SS_PASS: r_lo <= '0;
                SS_RUN: begin
                    if (run_done) begin
                        r_src <= ~r_src;
                        r_w   <= w2;
                    end else begin
                        r_a   <= r_lo[CNT_W-1:0];
                        r_k   <= r_lo[CNT_W-1:0];
                        r_mid <= mid_c;
                        r_b   <= mid_c;
                        r_hi  <= hi_c;
                    end
                end
                SS_LOAD_A:  r_head_a <= rdata;
                SS_LOAD_B:  r_head_b <= rdata;
                SS_MERGE: begin
                    if (merge_done) begin
                        r_lo <= hi_s;
                    end else begin
                        r_k <= r_k + CNT_W'(1);
                        if (take_left) begin
                            r_a <= a_inc;
                        end else begin
                            r_b <= b_inc;
                        end
                    end
                end
                SS_FETCH_A: r_head_a <= rdata;
                SS_FETCH_B: r_head_b <= rdata;
                default: ;
            endcase
        end
    end

endmodule

// ===== sv/merge_sort_buffer.sv =====
// Merge sort buffer: collects a batch of signed values (one per input transfer,
// up to DEPTH of them, the batch closed by last_item), sorts them stably in
// ascending order by bottom-up merge passes between two RAMs, and returns
// them one per output transfer with last_out on the final one. Elements that
// arrive while the store is full are discarded and every result of that batch
// carries dropped. Loading accepts one element per cycle; for a batch of N the
// sort makes ceil(log2 N) passes. For each element a pass compares and
// writes, then refills the consumed run head through the single registered
// read port; for each run pair it first primes both heads and finally
// closes the merge, and the run tails need no refill; each pass also does
// its own bookkeeping. Emitting reads each element, then captures it into
// the output register. No input is taken while sorting or emitting; the
// output register lets the next batch start loading while the final result
// is still waiting to be taken.
module merge_sort_buffer
    import msb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [OUT_W-1:0]  i_value,
    input  logic              i_last_item,
    // output channel
    output logic              o_valid,
    input  logic              i_stall,
    output logic [OUT_W-1:0]  o_sorted_value,
    output logic              o_last_out,
    output logic              o_dropped
);

    t_top_state r_state, n_state;

    logic [CNT_W-1:0]      r_fill;       // stored element count
    logic                  r_ovf;        // batch lost an element
    logic [CNT_W-1:0]      r_emit;       // next element to emit
    logic                  r_res_scratch;// sorted batch sits in scratch

    logic                  r_out_valid;
    logic [OUT_W-1:0]      r_out_data;
    logic                  r_out_last;
    logic                  r_out_drop;

    // control decoded from the state
    logic                  in_xfer, out_free, sort_start, sorting, cap;
    logic                  emit_last;

    t_ram_req              w_req;
    t_sort_status          w_sort_st;

    logic                  sto_we, scr_we;
    logic [IDX_W-1:0]      sto_waddr, rd_addr;
    logic [DATA_WIDTH-1:0] sto_wdata;
    logic [DATA_WIDTH-1:0] sto_q, scr_q, emit_q;

    assign in_xfer   = i_valid && !o_stall;
    assign out_free  = !r_out_valid || !i_stall;
    assign emit_last = ((r_emit + CNT_W'(1)) == r_fill);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD:      if (in_xfer && i_last_item) n_state = ST_SORT_GO;
            ST_SORT_GO:   n_state = ST_SORT_WAIT;
            ST_SORT_WAIT: if (w_sort_st.done) n_state = ST_EMIT_RD;
            ST_EMIT_RD:   if (out_free) n_state = ST_EMIT_CAP;
            ST_EMIT_CAP:  n_state = emit_last ? ST_LOAD : ST_EMIT_RD;
            default:      n_state = ST_LOAD;
        endcase
    end

    // state outputs
    always_comb begin
        o_stall    = 1'b1;
        sort_start = 1'b0;
        sorting    = 1'b0;
        cap        = 1'b0;
        unique case (r_state)
            ST_LOAD:      o_stall    = 1'b0;
            ST_SORT_GO:   sort_start = 1'b1;
            ST_SORT_WAIT: sorting    = 1'b1;
            ST_EMIT_CAP:  cap        = 1'b1;
            default: ;
        endcase
    end

    msb_sorter u_sorter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (sort_start),
        .i_count     (r_fill),
        .i_store_q   (sto_q),
        .i_scratch_q (scr_q),
        .o_req       (w_req),
        .o_status    (w_sort_st)
    );

    // RAM port steering: loader owns the store write port in LOAD, the sorter
    // owns both RAMs while sorting, the emitter reads the result buffer
    assign sto_we    = (in_xfer && (r_fill < CNT_W'(DEPTH)))
                     || (sorting && w_req.we && w_req.src_scratch);
    assign sto_waddr = sorting ? w_req.waddr : r_fill[IDX_W-1:0];
    assign sto_wdata = sorting ? w_req.wdata : i_value[DATA_WIDTH-1:0];
    assign scr_we    = sorting && w_req.we && !w_req.src_scratch;
    assign rd_addr   = sorting ? w_req.raddr : r_emit[IDX_W-1:0];

    msb_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (sto_we),
        .i_waddr (sto_waddr),
        .i_wdata (sto_wdata),
        .i_raddr (rd_addr),
        .o_rdata (sto_q)
    );

    msb_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_scratch (
        .i_clk   (i_clk),
        .i_we    (scr_we),
        .i_waddr (w_req.waddr),
        .i_wdata (w_req.wdata),
        .i_raddr (rd_addr),
        .o_rdata (scr_q)
    );

    assign emit_q = r_res_scratch ? scr_q : sto_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_LOAD;
            r_fill        <= '0;
            r_ovf         <= 1'b0;
            r_emit        <= '0;
            r_res_scratch <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;

            if (in_xfer) begin
                if (r_fill < CNT_W'(DEPTH)) begin
                    r_fill <= r_fill + CNT_W'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end

            if (sorting && w_sort_st.done) begin
                r_res_scratch <= w_sort_st.res_scratch;
                r_emit        <= '0;
            end

            // output register: capture wins, otherwise drain on transfer
            if (cap) begin
                r_out_valid <= 1'b1;
                r_emit      <= r_emit + CNT_W'(1);
                if (emit_last) begin
                    r_fill <= '0;
                    r_ovf  <= 1'b0;
                end
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload of the output register
    always_ff @(posedge i_clk) begin
        if (cap) begin
            r_out_data <= OUT_W'($signed(emit_q));
            r_out_last <= emit_last;
            r_out_drop <= r_ovf;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_sorted_value = r_out_data;
    assign o_last_out     = r_out_last;
    assign o_dropped      = r_out_drop;

    // a transfer into a full store must flag the batch
    a_ovf_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (r_fill == CNT_W'(DEPTH))) |=> r_ovf)
        else $error("overflow not flagged on full store");

    // a pending non-final result means the emitter is still on this batch
    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |-> (r_state == ST_EMIT_RD))
        else $error("non-final result pending outside emit");

    // the merge engine only finishes while the top level waits for it
    a_sort_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sort_st.done |-> (r_state == ST_SORT_WAIT))
        else $error("sort completion outside sort wait");

endmodule
